// ===== rtl/gcd_pair_counter_mobius_assert.svh =====
// assertion macros for the rtl, included by gpcm_dp
`ifndef GCD_PAIR_COUNTER_MOBIUS_ASSERT_SVH
`define GCD_PAIR_COUNTER_MOBIUS_ASSERT_SVH

`ifndef SYNTHESIS
`define GPCM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gpcm assertion failed");
`define GPCM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error("gpcm assertion failed");
`else
`define GPCM_ASSERT(lbl, prop)
`define GPCM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/gpcm_pkg.sv =====
`default_nettype none

package gpcm_pkg;

    localparam int LIM_W     = 16;
    localparam int CNT_W     = 32;
    localparam int MU_W      = 16;
    localparam int DIV_ITER  = LIM_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_ITER);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_SV_RD,
        ST_SV_HEAD,
        ST_SV_PRD,
        ST_SV_MARK,
        ST_SV_NEXT,
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_Q_TEST,
        ST_Q_RDHI,
        ST_Q_RDLO,
        ST_Q_MUL,
        ST_Q_ACC,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        DIV_BIG,
        DIV_SMALL,
        DIV_QA,
        DIV_QB,
        DIV_HI,
        DIV_JB
    } t_div_sel;

    typedef enum logic [1:0] {
        RD_SIEVE,
        RD_HI,
        RD_LO
    } t_rd_sel;

    typedef struct packed {
        logic     clr_wr;
        logic     sv_head;
        logic     sv_mark;
        logic     k_inc;
        logic     n_inc;
        logic     q_load;
        logic     div_start;
        t_div_sel div_sel;
        t_rd_sel  rd_sel;
        logic     q_cap_hi;
        logic     q_mul;
        logic     q_acc;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic n_end;
        logic k_end;
        logic over;
        logic hit;
        logic d_zero;
        logic div_done;
        logic lo_gt_small;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/gpcm_div.sv =====
`default_nettype none

module gpcm_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_num,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_den,
    output logic      [gpcm_pkg::LIM_W-1:0] o_quo,
    output logic                            o_busy,
    output logic                            o_done
);
    import gpcm_pkg::*;

    // restoring divider, two quotient bits a cycle
    logic [LIM_W:0]     r_rem, n_rem;
    logic [LIM_W-1:0]   r_num, n_num;
    logic [LIM_W-1:0]   r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic               r_busy;
    logic               r_done;

    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        for (int i = 0; i < 2; i++) begin
            n_rem = {n_rem[LIM_W-1:0], n_num[LIM_W-1]};
            n_num = {n_num[LIM_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem    = n_rem - {1'b0, r_den};
                n_num[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_num <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_quo  = r_num;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== rtl/gpcm_dp.sv =====
`default_nettype none

module gpcm_dp #(
    parameter int TABLE_SIZE  = 65536,
    parameter int PRIME_SLOTS = 6542
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire gpcm_pkg::t_cmd             i_cmd,
    output gpcm_pkg::t_status               o_status,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_limit_a,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_limit_b,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_gcd_target,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output logic      [gpcm_pkg::CNT_W-1:0] o_pair_count
);
    import gpcm_pkg::*;
    `include "gcd_pair_counter_mobius_assert.svh"

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int PL_AW = $clog2(PRIME_SLOTS);
    localparam int PC_W  = $clog2(PRIME_SLOTS + 1);
    localparam int PR_W  = 2 * IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SIZE - 1);
    localparam logic [PR_W-1:0]  PR_LIMIT = PR_W'(TABLE_SIZE);

    // smallest prime factor (zero while unmarked), mobius / prefix, primes
    logic [IDX_W-1:0]        lpf_mem [TABLE_SIZE];
    logic signed [MU_W-1:0]  mu_mem  [TABLE_SIZE];
    logic [IDX_W-1:0]        pl_mem  [PRIME_SLOTS];

    logic [IDX_W-1:0]        r_n, r_lpf_q, r_lpf_n, r_pl_q;
    logic signed [MU_W-1:0]  r_mu_q, r_mu_n, r_acc, r_m_hi;
    logic [PC_W-1:0]         r_k, r_pcnt;

    logic [LIM_W-1:0]        r_big_lim, r_small_lim, r_d;
    logic [LIM_W-1:0]        r_big, r_small, r_qa, r_qb, r_hi;
    logic [LIM_W:0]          r_lo;
    logic signed [MU_W:0]    r_diff;
    logic [CNT_W-1:0]        r_prod, r_total;
    logic                    r_out_valid;
    logic [CNT_W-1:0]        r_pair_count;

    logic                    is_prime;
    logic signed [MU_W-1:0]  mu_n, acc_new;
    logic [PR_W-1:0]         mark_prod;
    logic                    mark_over, mark_hit;
    logic                    mu_we, lpf_we;
    logic [IDX_W-1:0]        mu_wa, lpf_wa, rd_addr;
    logic signed [MU_W-1:0]  mu_wd;
    logic [IDX_W-1:0]        lpf_wd;
    logic [LIM_W-1:0]        div_num, div_den, div_quo, lo_m1, hi_min;
    logic                    div_busy, div_done;
    logic signed [MU_W+CNT_W+1:0] term;

    gpcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_busy  (div_busy),
        .o_done  (div_done)
    );

    // sieve step
    always_comb begin
        is_prime  = (r_lpf_q == '0);
        mu_n      = is_prime ? -MU_W'(1) : r_mu_q;
        acc_new   = r_acc + mu_n;
        mark_prod = PR_W'(r_n) * PR_W'(r_pl_q);
        mark_over = (mark_prod >= PR_LIMIT);
        mark_hit  = (r_pl_q == r_lpf_n);
    end

    // write ports
    always_comb begin
        mu_we  = 1'b0;
        mu_wa  = r_n;
        mu_wd  = '0;
        lpf_we = 1'b0;
        lpf_wa = r_n;
        lpf_wd = '0;
        if (i_cmd.clr_wr) begin
            mu_we  = 1'b1;
            mu_wd  = (r_n == IDX_W'(1)) ? MU_W'(1) : '0;
            lpf_we = 1'b1;
        end else if (i_cmd.sv_head) begin
            mu_we = 1'b1;
            mu_wd = acc_new;
        end else if (i_cmd.sv_mark && !mark_over) begin
            mu_we  = 1'b1;
            mu_wa  = mark_prod[IDX_W-1:0];
            mu_wd  = mark_hit ? '0 : -r_mu_n;
            lpf_we = 1'b1;
            lpf_wa = mark_prod[IDX_W-1:0];
            lpf_wd = r_pl_q;
        end
    end

    // mu / prefix read address: sieve index, or prefix index saturated at the table end
    always_comb begin
        lo_m1   = r_lo[LIM_W-1:0] - 1'b1;
        rd_addr = r_n;
        case (i_cmd.rd_sel)
            RD_HI:   rd_addr = (int'(r_hi) >= TABLE_SIZE) ? IDX_LAST : IDX_W'(r_hi);
            RD_LO:   rd_addr = (int'(lo_m1) >= TABLE_SIZE) ? IDX_LAST : IDX_W'(lo_m1);
            default: rd_addr = r_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mu_we)  mu_mem[mu_wa]   <= mu_wd;
        if (lpf_we) lpf_mem[lpf_wa] <= lpf_wd;
        if (i_cmd.sv_head && is_prime && (r_pcnt < PC_W'(PRIME_SLOTS))) begin
            pl_mem[r_pcnt[PL_AW-1:0]] <= r_n;
        end
        r_mu_q  <= mu_mem[rd_addr];
        r_lpf_q <= lpf_mem[r_n];
        r_pl_q  <= pl_mem[r_k[PL_AW-1:0]];
    end

    // divider operands
    always_comb begin
        case (i_cmd.div_sel)
            DIV_BIG:   begin div_num = r_big_lim;   div_den = r_d; end
            DIV_SMALL: begin div_num = r_small_lim; div_den = r_d; end
            DIV_QA:    begin div_num = r_big;       div_den = r_lo[LIM_W-1:0]; end
            DIV_QB:    begin div_num = r_small;     div_den = r_lo[LIM_W-1:0]; end
            DIV_HI:    begin div_num = r_big;       div_den = r_qa; end
            DIV_JB:    begin div_num = r_small;     div_den = r_qb; end
            default:   begin div_num = r_big;       div_den = LIM_W'(1); end
        endcase
        hi_min = (div_quo < r_hi) ? div_quo : r_hi;
        if (r_small < hi_min) hi_min = r_small;
        term = $signed(r_diff) * $signed({1'b0, r_prod});
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_k         <= '0;
            r_pcnt      <= '0;
            r_acc       <= MU_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_n <= (r_n == IDX_LAST) ? IDX_W'(2) : r_n + 1'b1;
            end else if (i_cmd.n_inc) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.sv_head) begin
                r_acc <= acc_new;
                r_k   <= '0;
                if (is_prime && (r_pcnt < PC_W'(PRIME_SLOTS))) r_pcnt <= r_pcnt + 1'b1;
            end else if (i_cmd.k_inc) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.sv_head) begin
            r_mu_n  <= mu_n;
            r_lpf_n <= is_prime ? r_n : r_lpf_q;
        end
        if (i_cmd.q_load) begin
            r_big_lim   <= (i_limit_a >= i_limit_b) ? i_limit_a : i_limit_b;
            r_small_lim <= (i_limit_a >= i_limit_b) ? i_limit_b : i_limit_a;
            r_d         <= i_gcd_target;
            r_total     <= '0;
            r_lo        <= (LIM_W + 1)'(1);
        end
        if (div_done) begin
            case (i_cmd.div_sel)
                DIV_BIG:   r_big   <= div_quo;
                DIV_SMALL: r_small <= div_quo;
                DIV_QA:    r_qa    <= div_quo;
                DIV_QB:    r_qb    <= div_quo;
                DIV_HI:    r_hi    <= div_quo;
                DIV_JB:    r_hi    <= hi_min;
                default:   r_hi    <= r_hi;
            endcase
        end
        if (i_cmd.q_cap_hi) r_m_hi <= r_mu_q;
        if (i_cmd.q_mul) begin
            r_diff <= {r_m_hi[MU_W-1], r_m_hi} - {r_mu_q[MU_W-1], r_mu_q};
            r_prod <= CNT_W'(r_qa) * CNT_W'(r_qb);
        end
        if (i_cmd.q_acc) begin
            r_total <= r_total + term[CNT_W-1:0];
            r_lo    <= {1'b0, r_hi} + 1'b1;
        end
        if (i_cmd.out_load) r_pair_count <= r_total;
    end

    always_comb begin
        o_status.n_end       = (r_n == IDX_LAST);
        o_status.k_end       = (r_k >= r_pcnt);
        o_status.over        = mark_over;
        o_status.hit         = mark_hit;
        o_status.d_zero      = (i_gcd_target == '0);
        o_status.div_done    = div_done;
        o_status.lo_gt_small = (r_lo > {1'b0, r_small});
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid  = r_out_valid;
    assign o_pair_count = r_pair_count;

    `GPCM_ASSERT(a_div_start_idle, i_cmd.div_start |-> !div_busy)
    `GPCM_ASSERT(a_mark_ahead, (i_cmd.sv_mark && !mark_over) |-> (mark_prod > PR_W'(r_n)))
    `GPCM_ASSERT_NEXT(a_hi_not_below_lo, (div_done && i_cmd.div_sel == DIV_JB), ({1'b0, r_hi} >= r_lo))

endmodule

`default_nettype wire

// ===== rtl/gpcm_ctrl.sv =====
`default_nettype none

module gpcm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire gpcm_pkg::t_status i_status,
    output gpcm_pkg::t_cmd         o_cmd
);
    import gpcm_pkg::*;

    t_state   r_state, n_state;
    t_div_sel r_div_sel, n_div_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_div_sel <= DIV_BIG;
        end else begin
            r_state   <= n_state;
            r_div_sel <= n_div_sel;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_sel = r_div_sel;
        unique case (r_state)
            ST_CLR:     if (i_status.n_end) n_state = ST_SV_RD;
            ST_SV_RD:   n_state = ST_SV_HEAD;
            ST_SV_HEAD: n_state = ST_SV_PRD;
            ST_SV_PRD:  n_state = i_status.k_end ? ST_SV_NEXT : ST_SV_MARK;
            ST_SV_MARK: n_state = (i_status.over || i_status.hit) ? ST_SV_NEXT : ST_SV_PRD;
            ST_SV_NEXT: n_state = i_status.n_end ? ST_IDLE : ST_SV_RD;
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.d_zero) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state   = ST_DIV_GO;
                        n_div_sel = DIV_BIG;
                    end
                end
            end
            ST_DIV_GO:  n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_DIV_GO;
                    case (r_div_sel)
                        DIV_BIG:   n_div_sel = DIV_SMALL;
                        DIV_SMALL: n_state   = ST_Q_TEST;
                        DIV_QA:    n_div_sel = DIV_QB;
                        DIV_QB:    n_div_sel = DIV_HI;
                        DIV_HI:    n_div_sel = DIV_JB;
                        DIV_JB:    n_state   = ST_Q_RDHI;
                        default:   n_state   = ST_Q_TEST;
                    endcase
                end
            end
            ST_Q_TEST: begin
                if (i_status.lo_gt_small) begin
                    n_state = ST_OUT;
                end else begin
                    n_state   = ST_DIV_GO;
                    n_div_sel = DIV_QA;
                end
            end
            ST_Q_RDHI:  n_state = ST_Q_RDLO;
            ST_Q_RDLO:  n_state = ST_Q_MUL;
            ST_Q_MUL:   n_state = ST_Q_ACC;
            ST_Q_ACC:   n_state = ST_Q_TEST;
            ST_OUT:     if (i_status.out_free) n_state = ST_IDLE;
            default:    n_state = ST_CLR;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = r_div_sel;
        o_cmd.rd_sel  = RD_SIEVE;
        o_in_stall    = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLR:     o_cmd.clr_wr = 1'b1;
            ST_SV_HEAD: o_cmd.sv_head = 1'b1;
            ST_SV_MARK: begin
                o_cmd.sv_mark = 1'b1;
                o_cmd.k_inc   = !(i_status.over || i_status.hit);
            end
            ST_SV_NEXT: o_cmd.n_inc = !i_status.n_end;
            ST_IDLE:    o_cmd.q_load = i_in_valid;
            ST_DIV_GO:  o_cmd.div_start = 1'b1;
            ST_Q_RDHI:  o_cmd.rd_sel = RD_HI;
            ST_Q_RDLO: begin
                o_cmd.q_cap_hi = 1'b1;
                o_cmd.rd_sel   = RD_LO;
            end
            ST_Q_MUL:   o_cmd.q_mul = 1'b1;
            ST_Q_ACC:   o_cmd.q_acc = 1'b1;
            ST_OUT:     o_cmd.out_load = i_status.out_free;
            default:    o_cmd.rd_sel = RD_SIEVE;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/gcd_pair_counter_mobius.sv =====
// counts pairs (x, y), x <= limit_a, y <= limit_b, with gcd(x, y) == gcd_target
// input channel: i_in_valid / o_in_stall with limit_a, limit_b, gcd_target
// output channel: o_out_valid / i_out_stall with pair_count, one beat per query
// after reset the block clears its factor table and then
// runs a linear sieve that builds the mertens prefix table;
// o_in_stall stays high the whole time
// a query then walks the blocks of equal quotients (up to about
// 2*sqrt(limit / gcd_target) blocks) before its result beat is valid; a
// zero target skips the walk and goes straight to the result; each block
// runs four divisions on the shared two-bits-per-cycle divider
// one query is worked on at a time; a new beat is taken once the previous
// result sits in the output register, even if the receiver still stalls it
// a stalled result holds in the output register until the beat is taken
`default_nettype none

module gcd_pair_counter_mobius #(
    parameter int TABLE_SIZE  = 65536,
    parameter int PRIME_SLOTS = 6542
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // query beat
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_limit_a,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_limit_b,
    input  wire logic [gpcm_pkg::LIM_W-1:0] i_gcd_target,
    // result beat
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic      [gpcm_pkg::CNT_W-1:0] o_pair_count
);
    import gpcm_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer for table clear, sieve and quotient-block walk
    gpcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // tables, divider, accumulator and output register
    gpcm_dp #(
        .TABLE_SIZE  (TABLE_SIZE),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_limit_a    (i_limit_a),
        .i_limit_b    (i_limit_b),
        .i_gcd_target (i_gcd_target),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_pair_count (o_pair_count)
    );

endmodule

`default_nettype wire
